### design/srrt_pkg.sv
`timescale 1ns / 1ps
package srrt_pkg;
   localparam int NAME_COUNT = 256;
   localparam int NAME_BITS = 8;
   localparam int RANGES = 8;
   localparam int RANGE_BITS = 3;
   localparam int KEY_BITS = 32;
   localparam int TOPIC_BITS = 16;
   localparam int DIRECT_DEPTH = 2 * NAME_COUNT;
   localparam int DIRECT_ABITS = 9;
   localparam int SLOT_DEPTH = 3 * NAME_COUNT;
   localparam int SLOT_ABITS = 10;
   localparam int RANGE_DEPTH = SLOT_DEPTH * RANGES;
   localparam int RANGE_ABITS = SLOT_ABITS + RANGE_BITS;

   localparam logic [1:0] FUNC_SET_DIRECT = 2'd0;
   localparam logic [1:0] FUNC_SET_WHOLE = 2'd1;
   localparam logic [1:0] FUNC_ADD_RANGE = 2'd2;
   localparam logic [1:0] FUNC_LOOKUP = 2'd3;

   localparam logic [2:0] KIND_ANY = 3'd5;
   localparam logic [2:0] KIND_CROSS = 3'd6;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_CROSS = 3'd4;
   localparam logic [2:0] ST_BAD = 3'd5;

   localparam int REQ_BITS = 2 + 3 + 1 + 8 + 16 + 32;
   localparam int REQ_BYTES_BITS = 64;

   // last member sits in the lowest bits: func at [1:0]
   typedef struct packed {
      logic [31:0] key;
      logic [15:0] topic_in;
      logic [7:0] name_index;
      logic by_key;
      logic [2:0] table_kind;
      logic [1:0] func;
   } req_type;

   // one-element key compare from the shared comparator
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;
endpackage

### design/sharded_range_routing_table_top.sv
`timescale 1ns / 1ps
// Shard routing table.
// Request channel req_*: one transfer per operation (set direct entry, set
// whole-table topic, add range, look up). Response channel rsp_*: exactly one
// transfer per request carrying topic_out and status.
// Each request is handled by a sequencer; the block drops req_tready while
// busy. For direct and whole-topic operations the sequencer passes through
// read, decide and response states, and req_tready returns the cycle after
// the response transfer. A keyed look up walks the stored ranges of the
// name with one shared comparator, one range per cycle. A sorted insert
// scans to the insert point, then shifts each range above it with a read
// state and a write state. Range storage lives in memories with registered
// reads, which sets the one-range-per-cycle pace.
// After reset a clearing pass over every slot zeroes the direct, whole-topic
// and count tables; no request is taken meanwhile. Range keys/topics are
// never cleared: only slots below the count are read.
// When the receiver stalls, the result holds in the output register and the
// next request waits until it is taken.
module sharded_range_routing_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], table_kind[4:2], by_key[5], name_index[13:6],
   // topic_in[29:14], key[61:30], zero[63:62]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // topic_out[15:0], status[18:16], zero[23:19]
   output logic [23:0] rsp_tdata
);
   import srrt_pkg::*;

   typedef enum logic [9:0] {
      S_CLEAR  = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_READ   = 10'b0000000100,
      S_DECIDE = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_SHIFTR = 10'b0000100000,
      S_SHIFTW = 10'b0001000000,
      S_INSERT = 10'b0010000000,
      S_RESP   = 10'b0100000000,
      S_WAIT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [TOPIC_BITS-1:0] direct_mem [DIRECT_DEPTH];
   logic [TOPIC_BITS-1:0] whole_mem [SLOT_DEPTH];
   logic [3:0]            count_mem [SLOT_DEPTH];
   logic [KEY_BITS-1:0]   key_mem [RANGE_DEPTH];
   logic [TOPIC_BITS-1:0] rtop_mem [RANGE_DEPTH];
   logic [8:0]            size_ff [5];

   req_type req_ff;
   logic [SLOT_ABITS-1:0] clr_ff;
   logic [TOPIC_BITS-1:0] direct_rd_ff, whole_rd_ff, rtop_rd_ff, hit_top_ff;
   logic [3:0] count_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [3:0] idx_ff, pos_ff;
   logic hit_ff, rsp_valid_ff;
   logic [TOPIC_BITS-1:0] rsp_topic_ff;
   logic [2:0] rsp_status_ff;

   logic [SLOT_ABITS-1:0] slot;
   logic [DIRECT_ABITS-1:0] daddr;
   logic [RANGE_ABITS-1:0] raddr_rd;
   logic [3:0] ridx;
   logic direct, ranged, name_known;
   cmp_type cmp;
   logic [2:0] kind_c;
   logic [TOPIC_BITS-1:0] res_topic;
   logic [2:0] res_status;
   logic res_set;

   assign kind_c = req_ff.table_kind;
   assign direct = kind_c <= 3'd1;
   assign ranged = kind_c inside {3'd2, 3'd3, 3'd4};
   assign slot = SLOT_ABITS'(({8'd0, kind_c} - 11'd2) * 11'(NAME_COUNT))
                 + SLOT_ABITS'(req_ff.name_index);
   assign daddr = {kind_c[0], req_ff.name_index};
   assign name_known = (direct || ranged)
                       && ({1'b0, req_ff.name_index} < size_ff[kind_c]);

   // range index being read: scan fetches the next entry ahead; shift reads idx-1
   assign ridx = (state_ff == S_SHIFTR) ? idx_ff - 4'd1
               : (state_ff == S_SCAN) ? idx_ff + 4'd1 : idx_ff;
   assign raddr_rd = {slot, ridx[RANGE_BITS-1:0]};

   srrt_cmp u_cmp (.a(key_rd_ff), .b(req_ff.key), .res(cmp));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'd0, rsp_status_ff, rsp_topic_ff};

   // memory ports: reads registered
   always_ff @(posedge clock) begin
      direct_rd_ff <= direct_mem[daddr];
      whole_rd_ff <= whole_mem[slot];
      count_rd_ff <= count_mem[slot];
      key_rd_ff <= key_mem[raddr_rd];
      rtop_rd_ff <= rtop_mem[raddr_rd];
      if (state_ff == S_CLEAR) begin
         whole_mem[clr_ff] <= '0;
         count_mem[clr_ff] <= '0;
         if (clr_ff < SLOT_ABITS'(DIRECT_DEPTH))
            direct_mem[clr_ff[DIRECT_ABITS-1:0]] <= '0;
      end else if (state_ff == S_DECIDE && res_set) begin
         if (req_ff.func == FUNC_SET_DIRECT) direct_mem[daddr] <= req_ff.topic_in;
         else whole_mem[slot] <= req_ff.topic_in;
      end else if (state_ff == S_SHIFTW) begin
         key_mem[{slot, idx_ff[RANGE_BITS-1:0]}] <= key_rd_ff;
         rtop_mem[{slot, idx_ff[RANGE_BITS-1:0]}] <= rtop_rd_ff;
      end else if (state_ff == S_INSERT) begin
         key_mem[{slot, pos_ff[RANGE_BITS-1:0]}] <= req_ff.key;
         rtop_mem[{slot, pos_ff[RANGE_BITS-1:0]}] <= req_ff.topic_in;
         count_mem[slot] <= count_rd_ff + 4'd1;
      end
   end

   // decision after the table reads
   always_comb begin
      res_topic = '0;
      res_status = ST_OK;
      res_set = 1'b0;
      if (req_ff.func == FUNC_LOOKUP && kind_c == KIND_ANY) begin
         res_status = ST_OK;
      end else if (req_ff.func == FUNC_LOOKUP && kind_c == KIND_CROSS) begin
         res_status = ST_CROSS;
      end else if (!(direct || ranged)) begin
         res_status = ST_BAD;
      end else if (req_ff.func == FUNC_LOOKUP) begin
         if (!name_known) res_status = ST_UNKNOWN;
         else if (direct) res_topic = direct_rd_ff;
         else res_topic = whole_rd_ff;
      end else if (req_ff.func == FUNC_SET_DIRECT) begin
         if (!direct) res_status = ST_BAD;
         else if (direct_rd_ff != '0) res_status = ST_DUP;
         else res_set = 1'b1;
      end else if (!ranged) begin
         res_status = ST_BAD;
      end else if (req_ff.func == FUNC_SET_WHOLE) begin
         if (whole_rd_ff != '0) res_status = ST_DUP;
         else res_set = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == SLOT_ABITS'(SLOT_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: state_in = S_DECIDE;
         S_DECIDE: begin
            if (ranged && ((req_ff.func == FUNC_LOOKUP && req_ff.by_key && name_known)
                           || req_ff.func == FUNC_ADD_RANGE))
               state_in = S_SCAN;
            else state_in = S_RESP;
         end
         S_SCAN: begin
            if (req_ff.func == FUNC_LOOKUP) begin
               if (idx_ff >= count_rd_ff || idx_ff == 4'(RANGES)) state_in = S_RESP;
            end else if (idx_ff >= count_rd_ff || !cmp.lt) begin
               if (idx_ff < count_rd_ff && cmp.eq) state_in = S_RESP;
               else if (count_rd_ff >= 4'(RANGES)) state_in = S_RESP;
               else if (count_rd_ff > idx_ff) state_in = S_SHIFTR;
               else state_in = S_INSERT;
            end
         end
         S_SHIFTR: state_in = S_SHIFTW;
         S_SHIFTW: state_in = (idx_ff - 4'd1 > pos_ff) ? S_SHIFTR : S_INSERT;
         S_INSERT: state_in = S_RESP;
         S_RESP: state_in = S_WAIT;
         S_WAIT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 5; k++) size_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + SLOT_ABITS'(1);
            S_IDLE: if (req_tvalid) req_ff <= req_type'(req_tdata[REQ_BITS-1:0]);
            // index 0 during decide so the first range is read ahead of the scan
            S_READ: begin
               idx_ff <= '0;
               hit_ff <= 1'b0;
            end
            S_DECIDE: begin
               rsp_topic_ff <= res_topic;
               rsp_status_ff <= res_status;
               // any set or add on a valid kind/func grows the size
               if (req_ff.func != FUNC_LOOKUP && res_status != ST_BAD
                   && {1'b0, req_ff.name_index} >= size_ff[kind_c])
                  size_ff[kind_c] <= {1'b0, req_ff.name_index} + 9'd1;
            end
            S_SCAN: begin
               if (req_ff.func == FUNC_LOOKUP) begin
                  if (idx_ff >= count_rd_ff || idx_ff == 4'(RANGES)) begin
                     rsp_topic_ff <= hit_ff ? hit_top_ff : '0;
                     rsp_status_ff <= hit_ff ? ST_OK : ST_UNKNOWN;
                  end else begin
                     if (cmp.lt || cmp.eq) begin
                        hit_ff <= 1'b1;
                        hit_top_ff <= rtop_rd_ff;
                     end
                     idx_ff <= idx_ff + 4'd1;
                  end
               end else if (idx_ff >= count_rd_ff || !cmp.lt) begin
                  pos_ff <= idx_ff;
                  idx_ff <= count_rd_ff;
                  if (idx_ff < count_rd_ff && cmp.eq) rsp_status_ff <= ST_DUP;
                  else if (count_rd_ff >= 4'(RANGES)) rsp_status_ff <= ST_FULL;
               end else idx_ff <= idx_ff + 4'd1;
            end
            S_SHIFTW: idx_ff <= idx_ff - 4'd1;
            S_RESP: rsp_valid_ff <= 1'b1;
            S_WAIT: if (rsp_tready) rsp_valid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // scan index stays in range
   a_scan_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> idx_ff <= 4'(RANGES)) else $error("scan index");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready) else $error("ready while result held");
   a_insert_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |-> count_rd_ff < 4'(RANGES)) else $error("insert full");
endmodule

### design/srrt_cmp.sv
`timescale 1ns / 1ps
module srrt_cmp (
   input  logic [srrt_pkg::KEY_BITS-1:0] a,
   input  logic [srrt_pkg::KEY_BITS-1:0] b,
   output srrt_pkg::cmp_type             res
);
   import srrt_pkg::*;
   // the single shared key comparator
   assign res.lt = a < b;
   assign res.eq = a == b;
endmodule

### sim/sharded_range_routing_table_top_tb.sv
`timescale 1ns / 1ps
module sharded_range_routing_table_top_tb;
   import srrt_pkg::*;

   // expected routing answer for one request
   typedef struct {
      logic [15:0] topic;
      logic [2:0] status;
   } answer_type;

   // shadow of the routing table; computes the answer of each accepted request
   class route_scoreboard;
      logic [15:0] direct_tab[DIRECT_DEPTH];
      logic [15:0] whole_tab[SLOT_DEPTH];
      logic [31:0] rkey[SLOT_DEPTH][RANGES];
      logic [15:0] rtop[SLOT_DEPTH][RANGES];
      int rcnt[SLOT_DEPTH];
      int ksize[5];
      answer_type pending[$];
      int errors;
      int mism;

      function new();
         foreach (direct_tab[i]) direct_tab[i] = '0;
         foreach (whole_tab[i]) whole_tab[i] = '0;
         foreach (rcnt[i]) rcnt[i] = 0;
         foreach (ksize[i]) ksize[i] = 0;
         errors = 0;
         mism = 0;
      endfunction

      function logic [2:0] insert_range(int slot, logic [31:0] k, logic [15:0] t);
         int n;
         int pos;
         n = rcnt[slot];
         pos = 0;
         while (pos < n && rkey[slot][pos] < k) pos++;
         if (pos < n && rkey[slot][pos] == k) return ST_DUP;
         if (n >= RANGES) return ST_FULL;
         for (int i = n; i > pos; i--) begin
            rkey[slot][i] = rkey[slot][i-1];
            rtop[slot][i] = rtop[slot][i-1];
         end
         rkey[slot][pos] = k;
         rtop[slot][pos] = t;
         rcnt[slot] = n + 1;
         return ST_OK;
      endfunction

      function void note_request(req_type r);
         answer_type a;
         int kind;
         int slot;
         logic hit;
         kind = r.table_kind;
         a.topic = '0;
         a.status = ST_OK;
         slot = (kind - 2) * NAME_COUNT + r.name_index;
         if (r.func == FUNC_LOOKUP && r.table_kind == KIND_ANY) a.status = ST_OK;
         else if (r.func == FUNC_LOOKUP && r.table_kind == KIND_CROSS) a.status = ST_CROSS;
         else if (kind > 4) a.status = ST_BAD;
         else if (r.func == FUNC_LOOKUP) begin
            if (r.name_index >= ksize[kind]) a.status = ST_UNKNOWN;
            else if (kind <= 1) a.topic = direct_tab[kind * NAME_COUNT + r.name_index];
            else if (!r.by_key) a.topic = whole_tab[slot];
            else begin
               hit = 0;
               for (int i = 0; i < rcnt[slot]; i++)
                  if (rkey[slot][i] <= r.key) begin
                     a.topic = rtop[slot][i];
                     hit = 1;
                  end
               if (!hit) a.status = ST_UNKNOWN;
            end
         end else if (r.func == FUNC_SET_DIRECT) begin
            if (kind > 1) a.status = ST_BAD;
            else begin
               if (ksize[kind] <= r.name_index) ksize[kind] = r.name_index + 1;
               if (direct_tab[kind * NAME_COUNT + r.name_index] != 0) a.status = ST_DUP;
               else direct_tab[kind * NAME_COUNT + r.name_index] = r.topic_in;
            end
         end else if (kind <= 1) a.status = ST_BAD;
         else begin
            if (ksize[kind] <= r.name_index) ksize[kind] = r.name_index + 1;
            if (r.func == FUNC_SET_WHOLE) begin
               if (whole_tab[slot] != 0) a.status = ST_DUP;
               else whole_tab[slot] = r.topic_in;
            end else a.status = insert_range(slot, r.key, r.topic_in);
         end
         if (a.status != ST_OK) a.topic = '0;
         pending.push_back(a);
      endfunction

      function void check_result(logic [23:0] d);
         answer_type a;
         if (pending.size() == 0) begin
            errors++;
            if (mism++ < 10) $display("unexpected response transfer %h", d);
            return;
         end
         a = pending.pop_front();
         if (d[15:0] !== a.topic || d[18:16] !== a.status || d[23:19] !== 5'd0) begin
            errors++;
            if (mism++ < 10)
               $display("mismatch: exp topic %h status %0d, got topic %h status %0d",
                  a.topic, a.status, d[15:0], d[18:16]);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;

   route_scoreboard sb = new();
   bit hold_on = 0;      // long receiver stall in progress
   int rx_wait = 0;      // receiver wait before taking the current result
   bit stim_done = 0;
   // names used by random traffic: a few per kind so ranges fill up
   int unsigned hot_names[4] = '{0, 1, 7, 255};

   always #4 clock = ~clock;

   sharded_range_routing_table_top i_dut (.*);

   // one request transfer, with a random gap before it
   task automatic send_request(logic [1:0] f, logic [2:0] k, logic bk, logic [7:0] n,
                               logic [15:0] t, logic [31:0] ky);
      req_type r;
      int gap;
      r.func = f;
      r.table_kind = k;
      r.by_key = bk;
      r.name_index = n;
      r.topic_in = t;
      r.key = ky;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b00, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // receiver: random wait per result plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rx_wait = $urandom_range(0, 7);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            rx_wait = $urandom_range(0, 7);
         end else if (rsp_tvalid && rx_wait > 0) begin
            rx_wait--;
         end
         if (hold_on) rsp_tready <= 0;
         else rsp_tready <= (rx_wait == 0);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: extremes, every function, special cases
      send_request(FUNC_LOOKUP, 3'd0, 0, 0, 0, 0);            // unknown name
      send_request(FUNC_SET_DIRECT, 3'd0, 0, 8'd255, 16'hFFFF, 0);
      send_request(FUNC_SET_DIRECT, 3'd0, 0, 8'd255, 16'h1234, 0); // already set
      send_request(FUNC_SET_DIRECT, 3'd1, 1, 8'd3, 16'h0, 0);   // topic 0 stays unset
      send_request(FUNC_LOOKUP, 3'd1, 1, 8'd3, 0, 0);           // known, unset
      send_request(FUNC_LOOKUP, 3'd0, 0, 8'd255, 0, 32'hFFFF_FFFF);
      send_request(FUNC_SET_DIRECT, 3'd2, 0, 0, 16'h5, 0);      // bad on range kind
      send_request(FUNC_SET_WHOLE, 3'd0, 0, 0, 16'h5, 0);       // bad on direct kind
      send_request(FUNC_ADD_RANGE, 3'd1, 0, 0, 16'h5, 0);
      send_request(FUNC_SET_WHOLE, 3'd5, 0, 0, 16'h5, 0);       // any cell set
      send_request(FUNC_ADD_RANGE, 3'd6, 0, 0, 16'h5, 0);       // cross cell add
      send_request(FUNC_LOOKUP, 3'd5, 1, 8'd9, 16'hFFFF, 1);    // any cell look up
      send_request(FUNC_LOOKUP, 3'd6, 0, 8'd9, 0, 1);           // cross cell
      send_request(FUNC_LOOKUP, 3'd7, 1, 0, 0, 0);              // kind 7
      send_request(FUNC_SET_WHOLE, 3'd4, 0, 8'd200, 16'hABCD, 0);
      send_request(FUNC_LOOKUP, 3'd4, 0, 8'd200, 0, 0);
      send_request(FUNC_ADD_RANGE, 3'd3, 0, 8'd1, 16'h11, 32'd100);
      send_request(FUNC_ADD_RANGE, 3'd3, 0, 8'd1, 16'h22, 32'd50);
      send_request(FUNC_ADD_RANGE, 3'd3, 0, 8'd1, 16'h33, 32'd100); // duplicate key
      send_request(FUNC_LOOKUP, 3'd3, 1, 8'd1, 0, 32'd49);      // below every range
      send_request(FUNC_LOOKUP, 3'd3, 1, 8'd1, 0, 32'd75);
      send_request(FUNC_LOOKUP, 3'd3, 1, 8'd1, 0, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++)                                // fill, then full
         send_request(FUNC_ADD_RANGE, 3'd2, 0, 8'd0, 16'(16'hFFFF - i),
                      32'(32'hFFFF_FFFF - 7 + i));
      send_request(FUNC_ADD_RANGE, 3'd2, 0, 8'd0, 16'h1, 32'd0);

      // sender pause until all results are in
      drain();

      // long receiver stall while the sender keeps offering
      fork
         begin
            hold_on <= 1;
            repeat (200) @(posedge clock);
            hold_on <= 0;
         end
      join_none
      for (int i = 0; i < 1700; i++) begin
         logic [1:0] f;
         logic [2:0] k;
         logic [7:0] n;
         if (i == 600) drain();
         f = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) begin
            k = 3'($urandom_range(0, 7));        // noise, any kind/function
            n = 8'($urandom());
         end else begin
            k = (f == FUNC_SET_DIRECT) ? 3'($urandom_range(0, 1)) :
                (f == FUNC_LOOKUP) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(2, 4));
            n = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                             : 8'(hot_names[$urandom_range(0, 3)]);
         end
         send_request(f, k, 1'($urandom_range(0, 1)), n,
                      ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom()), rand_key());
      end
      drain();
      repeat (50) @(posedge clock);
      stim_done = 1;
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(5_000_000);
      if (!stim_done) $display("status: fail");
      $finish;
   end
endmodule
